// ===== rtl/dmwbc_pkg.sv =====
// shared types, constants and codes for the direct-mapped write-back cache
// no dependencies
`default_nettype none

package dmwbc_pkg;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 32;
    localparam int COST_W       = 16;
    localparam int TIME_W       = 32;

    localparam int LINE_COUNT   = 256;
    localparam int BLOCK_BYTES  = 64;
    localparam int MEMORY_BYTES = 65536;
    localparam int WORD_BYTES   = 4;

    localparam int WPB       = BLOCK_BYTES / WORD_BYTES;
    localparam int WOFF_W    = $clog2(WPB);
    localparam int IDX_W     = $clog2(LINE_COUNT);
    localparam int BOFF_W    = $clog2(WORD_BYTES);
    localparam int MEM_WORDS = MEMORY_BYTES / WORD_BYTES;
    localparam int MEM_W     = $clog2(MEM_WORDS);
    localparam int TAG_W     = MEM_W - IDX_W - WOFF_W;
    localparam int DATA_AW   = IDX_W + WOFF_W;
    localparam int CNT_W     = WOFF_W + 1;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_READ  = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_CLEAR = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DRAM_RD = 2'd0;
    localparam t_cfg_idx CFG_DRAM_WR = 2'd1;
    localparam t_cfg_idx CFG_L1_RD   = 2'd2;
    localparam t_cfg_idx CFG_L1_WR   = 2'd3;

    typedef struct packed {
        logic [COST_W-1:0] dram_rd;
        logic [COST_W-1:0] dram_wr;
        logic [COST_W-1:0] l1_rd;
        logic [COST_W-1:0] l1_wr;
    } t_costs;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [TAG_W-1:0] wtag;
        logic             wdirty;
    } t_tag_req;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_tag_rsp;

    typedef struct packed {
        logic               re;
        logic [DATA_AW-1:0] raddr;
        logic               we;
        logic [DATA_AW-1:0] waddr;
        logic [DATA_W-1:0]  wdata;
    } t_data_req;

    typedef struct packed {
        logic              re;
        logic [MEM_W-1:0]  raddr;
        logic              we;
        logic [MEM_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
    } t_back_req;

endpackage

`default_nettype wire

// ===== rtl/direct_mapped_writeback_cache_unit.sv =====
// Path, transfer to result transfer: hit: lookup, response; clear or ignored command:
// response only; clean miss: lookup, block fill, response; dirty miss: lookup, a block
// write-back (one word per cycle into the backing memory), block fill, response.
// One item in flight, so a new transfer is taken only after the last one has left S_RESP;
// the next transfer is taken while the last result waits. Reset: valid bits, time counter
// and costs reset at once; a sweep zeroes the backing memory, no item taken until it ends.
`default_nettype none

module direct_mapped_writeback_cache_unit import dmwbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_read_data,
    output logic                   o_hit,
    output logic                   o_wrote_back,
    output logic [TIME_W-1:0]      o_elapsed_time,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [COST_W-1:0] i_cfg_data
);

    t_costs            r_costs;
    t_tag_req          w_tag_req;
    t_tag_rsp          w_tag_rsp;
    t_data_req         w_data_req;
    t_back_req         w_back_req;
    logic [DATA_W-1:0] w_data_rdata;
    logic [DATA_W-1:0] w_back_rdata;
    logic              w_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_costs.dram_rd <= COST_W'(100);
            r_costs.dram_wr <= COST_W'(50);
            r_costs.l1_rd   <= COST_W'(1);
            r_costs.l1_wr   <= COST_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DRAM_RD: r_costs.dram_rd <= i_cfg_data;
                CFG_DRAM_WR: r_costs.dram_wr <= i_cfg_data;
                CFG_L1_RD:   r_costs.l1_rd   <= i_cfg_data;
                CFG_L1_WR:   r_costs.l1_wr   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dmwbc_tag_store u_tag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tag_req),
        .o_rsp   (w_tag_rsp)
    );

    dmwbc_data_store u_data (
        .i_clk   (i_clk),
        .i_req   (w_data_req),
        .o_rdata (w_data_rdata)
    );

    dmwbc_backing u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_back_req),
        .o_rdata (w_back_rdata),
        .o_busy  (w_busy)
    );

    dmwbc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_costs        (r_costs),
        .i_busy         (w_busy),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_hit          (o_hit),
        .o_wrote_back   (o_wrote_back),
        .o_elapsed_time (o_elapsed_time),
        .o_tag_req      (w_tag_req),
        .i_tag_rsp      (w_tag_rsp),
        .o_data_req     (w_data_req),
        .i_data_rdata   (w_data_rdata),
        .o_back_req     (w_back_req),
        .i_back_rdata   (w_back_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/dmwbc_tag_store.sv =====
// tag and dirty memory with per-line valid flops, registered read
// depends on dmwbc_pkg
`default_nettype none

module dmwbc_tag_store import dmwbc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_tag_req i_req,
    output t_tag_rsp      o_rsp
);

    logic [TAG_W:0]          r_mem [LINE_COUNT];
    logic [LINE_COUNT-1:0]   r_valid;
    logic [TAG_W:0]          r_rd_word;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= {i_req.wdirty, i_req.wtag};
        end
        if (i_req.re) begin
            r_rd_word <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.raddr];
            end
        end
    end

    assign o_rsp.valid = r_rd_valid;
    assign o_rsp.dirty = r_rd_word[TAG_W];
    assign o_rsp.tag   = r_rd_word[TAG_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/dmwbc_data_store.sv =====
// cached word memory, one write and one registered read per cycle
// depends on dmwbc_pkg
`default_nettype none

module dmwbc_data_store import dmwbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_data_req         i_req,
    output logic [DATA_W-1:0]      o_rdata
);

    logic [DATA_W-1:0] r_mem [LINE_COUNT * WPB];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/dmwbc_backing.sv =====
// backing word memory with a zeroing sweep after reset
// depends on dmwbc_pkg
`default_nettype none

module dmwbc_backing import dmwbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_back_req         i_req,
    output logic [DATA_W-1:0]      o_rdata,
    output logic                   o_busy
);

    logic [DATA_W-1:0] r_mem [MEM_WORDS];
    logic [DATA_W-1:0] r_rdata;
    logic [MEM_W-1:0]  r_clr_addr;
    logic              r_clr_busy;

    logic              w_we;
    logic [MEM_W-1:0]  w_waddr;
    logic [DATA_W-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MEM_W'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // the sweep owns the write port until every word is zero
    assign w_we    = r_clr_busy | i_req.we;
    assign w_waddr = r_clr_busy ? r_clr_addr : i_req.waddr;
    assign w_wdata = r_clr_busy ? '0 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

`default_nettype wire

// ===== rtl/dmwbc_ctrl.sv =====
// access sequencer: lookup, victim write-back, block fill, time counter, result register
// depends on dmwbc_pkg; drives the tag, data and backing memories
`default_nettype none

module dmwbc_ctrl import dmwbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_costs            i_costs,
    input  wire logic              i_busy,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_read_data,
    output logic                   o_hit,
    output logic                   o_wrote_back,
    output logic [TIME_W-1:0]      o_elapsed_time,
    output t_tag_req               o_tag_req,
    input  wire t_tag_rsp          i_tag_rsp,
    output t_data_req              o_data_req,
    input  wire logic [DATA_W-1:0] i_data_rdata,
    output t_back_req              o_back_req,
    input  wire logic [DATA_W-1:0] i_back_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_WB     = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend;
    logic [WOFF_W-1:0] r_pcnt;
    logic [TIME_W-1:0] r_time;
    logic              r_out_valid;

    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic [TAG_W-1:0]  r_tag;
    logic [TAG_W-1:0]  r_vtag;
    logic [WOFF_W-1:0] r_woff;
    logic [DATA_W-1:0] r_wdata;
    logic [DATA_W-1:0] r_rdata;
    logic              r_hit;
    logic              r_wb;

    logic [DATA_W-1:0] r_out_rdata;
    logic              r_out_hit;
    logic              r_out_wb;
    logic [TIME_W-1:0] r_out_time;

    logic              w_accept;
    logic              w_mem_cmd;
    logic              w_hit;
    logic              w_out_free;
    logic              w_cnt_done;
    logic [WOFF_W-1:0] w_in_woff;
    logic [IDX_W-1:0]  w_in_idx;
    logic [TAG_W-1:0]  w_in_tag;
    logic [COST_W-1:0] w_l1_cost;

    assign o_in_ready = (r_state == S_IDLE) && !i_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_mem_cmd  = (i_command == CMD_READ) || (i_command == CMD_WRITE);
    assign w_hit      = i_tag_rsp.valid && (i_tag_rsp.tag == r_tag);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_cnt_done = r_cnt[WOFF_W];
    assign w_l1_cost  = (r_cmd == CMD_WRITE) ? i_costs.l1_wr : i_costs.l1_rd;

    assign w_in_woff = i_address[BOFF_W +: WOFF_W];
    assign w_in_idx  = i_address[BOFF_W + WOFF_W +: IDX_W];
    assign w_in_tag  = i_address[BOFF_W + WOFF_W + IDX_W +: TAG_W];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_mem_cmd ? S_LOOKUP : S_RESP;
                end
            end
            S_LOOKUP: begin
                if (w_hit) begin
                    n_state = S_RESP;
                end else if (i_tag_rsp.valid && i_tag_rsp.dirty) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_WB: begin
                if (w_cnt_done) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (w_cnt_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory requests
    always_comb begin
        o_tag_req  = '0;
        o_data_req = '0;
        o_back_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_mem_cmd) begin
                    o_tag_req.re     = 1'b1;
                    o_tag_req.raddr  = w_in_idx;
                    o_data_req.re    = 1'b1;
                    o_data_req.raddr = {w_in_idx, w_in_woff};
                end
            end
            S_LOOKUP: begin
                if (w_hit && (r_cmd == CMD_WRITE)) begin
                    o_data_req.we    = 1'b1;
                    o_data_req.waddr = {r_idx, r_woff};
                    o_data_req.wdata = r_wdata;
                    o_tag_req.we     = 1'b1;
                    o_tag_req.waddr  = r_idx;
                    o_tag_req.wtag   = r_tag;
                    o_tag_req.wdirty = 1'b1;
                end
            end
            S_WB: begin
                if (!w_cnt_done) begin
                    o_data_req.re    = 1'b1;
                    o_data_req.raddr = {r_idx, r_cnt[WOFF_W-1:0]};
                end
                if (r_pend) begin
                    o_back_req.we    = 1'b1;
                    o_back_req.waddr = {r_vtag, r_idx, r_pcnt};
                    o_back_req.wdata = i_data_rdata;
                end
            end
            S_FILL: begin
                if (!w_cnt_done) begin
                    o_back_req.re    = 1'b1;
                    o_back_req.raddr = {r_tag, r_idx, r_cnt[WOFF_W-1:0]};
                end
                if (r_pend) begin
                    o_data_req.we    = 1'b1;
                    o_data_req.waddr = {r_idx, r_pcnt};
                    // the word being written lands in place of the fetched one
                    o_data_req.wdata = ((r_pcnt == r_woff) && (r_cmd == CMD_WRITE))
                                       ? r_wdata : i_back_rdata;
                end
                if (w_cnt_done) begin
                    o_tag_req.we     = 1'b1;
                    o_tag_req.waddr  = r_idx;
                    o_tag_req.wtag   = r_tag;
                    o_tag_req.wdirty = (r_cmd == CMD_WRITE);
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_RESP) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_command == CMD_CLEAR)) begin
                        r_time <= '0;
                    end
                end
                S_LOOKUP: begin
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    if (w_hit) begin
                        r_time <= r_time + TIME_W'(w_l1_cost);
                    end else begin
                        r_time <= r_time + TIME_W'(i_costs.dram_rd);
                    end
                end
                S_WB: begin
                    if (!w_cnt_done) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_cnt  <= '0;
                        r_pend <= 1'b0;
                        r_time <= r_time + TIME_W'(i_costs.dram_wr);
                    end
                end
                S_FILL: begin
                    if (!w_cnt_done) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_cnt  <= '0;
                        r_pend <= 1'b0;
                        r_time <= r_time + TIME_W'(w_l1_cost);
                    end
                end
                S_RESP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcnt <= r_cnt[WOFF_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cmd   <= i_command;
                    r_idx   <= w_in_idx;
                    r_tag   <= w_in_tag;
                    r_woff  <= w_in_woff;
                    r_wdata <= i_write_data;
                    r_rdata <= '0;
                    r_hit   <= 1'b0;
                    r_wb    <= 1'b0;
                end
            end
            S_LOOKUP: begin
                r_vtag <= i_tag_rsp.tag;
                if (w_hit) begin
                    r_hit <= 1'b1;
                    if (r_cmd == CMD_READ) begin
                        r_rdata <= i_data_rdata;
                    end
                end else if (i_tag_rsp.valid && i_tag_rsp.dirty) begin
                    r_wb <= 1'b1;
                end
            end
            S_FILL: begin
                if (r_pend && (r_pcnt == r_woff) && (r_cmd == CMD_READ)) begin
                    r_rdata <= i_back_rdata;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    r_out_rdata <= r_rdata;
                    r_out_hit   <= r_hit;
                    r_out_wb    <= r_wb;
                    r_out_time  <= r_time;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_rdata;
    assign o_hit          = r_out_hit;
    assign o_wrote_back   = r_out_wb;
    assign o_elapsed_time = r_out_time;

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |-> !(r_hit && r_wb))
        else $error("write-back reported on a hit");

    a_resp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !i_out_ready) |=>
        (r_state == S_RESP && r_out_valid))
        else $error("result register overwritten while stalled");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_WB || r_state == S_FILL))
        else $error("pending word outside block transfer");

    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && w_cnt_done) |=> (r_state == S_RESP))
        else $error("fill did not finish into response");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !i_busy)
        else $error("item taken during memory clear");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for direct_mapped_writeback_cache_unit: random and directed accesses
// checked against a behavioral cache model held in the bench
// depends on dmwbc_pkg and the cache unit rtl
`timescale 1ns / 100ps

module tb;
    import dmwbc_pkg::*;

    localparam t_cmd CMD_UNUSED = 2'd3;
    localparam int   MAX_IDLE   = 14;
    localparam int   LONG_HOLD  = 400;
    localparam int   END_WAIT   = 40;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic              wrote_back;
        logic [TIME_W-1:0] elapsed_time;
    } t_access_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_command;
    logic [ADDR_W-1:0] i_address;
    logic [DATA_W-1:0] i_write_data;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_read_data;
    logic              o_hit;
    logic              o_wrote_back;
    logic [TIME_W-1:0] o_elapsed_time;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [COST_W-1:0] i_cfg_data;

    // model of the cache contents, backing memory and cost clock
    logic              tag_valid   [LINE_COUNT];
    logic              tag_dirty   [LINE_COUNT];
    logic [TAG_W-1:0]  tag_value   [LINE_COUNT];
    logic [DATA_W-1:0] cached_word [LINE_COUNT*WPB];
    logic [DATA_W-1:0] memory_word [MEM_WORDS];
    logic [TIME_W-1:0] access_clock;
    t_costs            costs;

    t_access_result awaited_results [$];
    int  fail_count = 0;
    bit  gaps_on    = 1'b1;
    bit  stalls_on  = 1'b1;
    bit  hold_req   = 1'b0;

    direct_mapped_writeback_cache_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_hit          (o_hit),
        .o_wrote_back   (o_wrote_back),
        .o_elapsed_time (o_elapsed_time),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_access_result compute_access_result(input t_cmd cmd,
                                                             input logic [ADDR_W-1:0] addr,
                                                             input logic [DATA_W-1:0] wdata);
        t_access_result     r;
        logic [IDX_W-1:0]   idx;
        logic [TAG_W-1:0]   tag;
        logic [WOFF_W-1:0]  woff;
        logic [DATA_AW-1:0] lbase;
        logic [MEM_W-1:0]   vbase;
        logic [MEM_W-1:0]   fbase;
        int                 i;
        r.read_data  = '0;
        r.hit        = 1'b0;
        r.wrote_back = 1'b0;
        if (cmd == CMD_CLEAR) begin
            access_clock = '0;
        end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
            woff  = addr[BOFF_W +: WOFF_W];
            idx   = addr[BOFF_W+WOFF_W +: IDX_W];
            tag   = addr[ADDR_W-1 -: TAG_W];
            lbase = {idx, {WOFF_W{1'b0}}};
            if (tag_valid[idx] && tag_value[idx] == tag) begin
                r.hit = 1'b1;
            end else begin
                access_clock += costs.dram_rd;
                if (tag_valid[idx] && tag_dirty[idx]) begin
                    vbase = {tag_value[idx], idx, {WOFF_W{1'b0}}};
                    for (i = 0; i < WPB; i++)
                        memory_word[vbase + i] = cached_word[lbase + i];
                    access_clock += costs.dram_wr;
                    r.wrote_back = 1'b1;
                end
                fbase = {tag, idx, {WOFF_W{1'b0}}};
                for (i = 0; i < WPB; i++)
                    cached_word[lbase + i] = memory_word[fbase + i];
                tag_valid[idx] = 1'b1;
                tag_dirty[idx] = 1'b0;
                tag_value[idx] = tag;
            end
            if (cmd == CMD_READ) begin
                r.read_data = cached_word[lbase + woff];
                access_clock += costs.l1_rd;
            end else begin
                cached_word[lbase + woff] = wdata;
                access_clock += costs.l1_wr;
                tag_dirty[idx] = 1'b1;
            end
        end
        r.elapsed_time = access_clock;
        return r;
    endfunction

    task automatic apply_reset();
        int k;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_READ;
        i_address    = '0;
        i_write_data = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_DRAM_RD;
        i_cfg_data   = '0;
        for (k = 0; k < LINE_COUNT; k++) begin
            tag_valid[k] = 1'b0;
            tag_dirty[k] = 1'b0;
            tag_value[k] = '0;
        end
        for (k = 0; k < LINE_COUNT*WPB; k++) cached_word[k] = '0;
        for (k = 0; k < MEM_WORDS; k++) memory_word[k] = '0;
        access_clock = '0;
        costs.dram_rd = 16'd100;
        costs.dram_wr = 16'd50;
        costs.l1_rd   = 16'd1;
        costs.l1_wr   = 16'd1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // four back-to-back register writes, valid held high between them
    task automatic set_costs(input logic [COST_W-1:0] dram_rd, dram_wr, l1_rd, l1_wr);
        t_cfg_idx          order [4];
        logic [COST_W-1:0] vals  [4];
        int                k;
        order = '{CFG_DRAM_RD, CFG_DRAM_WR, CFG_L1_RD, CFG_L1_WR};
        vals  = '{dram_rd, dram_wr, l1_rd, l1_wr};
        for (k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (order[k])
                CFG_DRAM_RD: costs.dram_rd = vals[k];
                CFG_DRAM_WR: costs.dram_wr = vals[k];
                CFG_L1_RD:   costs.l1_rd   = vals[k];
                CFG_L1_WR:   costs.l1_wr   = vals[k];
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input t_cmd cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_address    <= addr;
        i_write_data <= wdata;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_results.push_back(compute_access_result(cmd, addr, wdata));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic t_cmd pick_command();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return CMD_CLEAR;
        if (r == 1) return CMD_UNUSED;
        if (r <= 10) return CMD_READ;
        return CMD_WRITE;
    endfunction

    // mostly a few hot lines with all four tags, so hits and dirty evictions are frequent
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [IDX_W-1:0] idx;
        if ($urandom_range(0, 9) < 2) return ADDR_W'($urandom);
        idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 3))
                                   : IDX_W'(LINE_COUNT - 4 + $urandom_range(0, 3));
        return {TAG_W'($urandom_range(0, 3)), idx, WOFF_W'($urandom_range(0, WPB-1)),
                BOFF_W'($urandom_range(0, 3))};
    endfunction

    task automatic run_random(input int count);
        int   done;
        t_cmd cmd;
        done = 0;
        while (done < count) begin
            cmd = pick_command();
            send_item(cmd, pick_address(), $urandom);
            if (cmd != CMD_UNUSED) done++;
        end
    endtask

    task automatic test_directed();
        send_item(CMD_READ,   16'h0000, 32'h0000_0000);
        send_item(CMD_WRITE,  16'h0004, 32'hFFFF_FFFF);
        send_item(CMD_READ,   16'h0007, 32'hFFFF_FFFF);
        send_item(CMD_WRITE,  16'h4004, 32'h0000_0000);
        send_item(CMD_READ,   16'h0004, 32'h0000_0000);
        send_item(CMD_READ,   16'hFFFF, 32'h0000_0000);
        send_item(CMD_WRITE,  16'hFFFC, 32'hA5A5_A5A5);
        send_item(CMD_WRITE,  16'hBFFC, 32'h5A5A_5A5A);
        send_item(CMD_READ,   16'hFFFE, 32'h0000_0000);
        send_item(CMD_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_READ,   16'hFFF8, 32'h0000_0000);
        // ignored command must leave the line and the clock untouched
        send_item(CMD_UNUSED, 16'h0004, 32'hDEAD_BEEF);
        send_item(CMD_READ,   16'h0004, 32'h0000_0000);
        send_item(CMD_WRITE,  16'h8000, 32'h1234_5678);
        send_item(CMD_WRITE,  16'h8000, 32'h8765_4321);
        send_item(CMD_READ,   16'h803C, 32'h0000_0000);
        send_item(CMD_READ,   16'h8001, 32'h0000_0000);
        send_item(CMD_CLEAR,  16'h0000, 32'h0000_0000);
        send_item(CMD_READ,   16'hBFFC, 32'h0000_0000);
        drain();
    endtask

    task automatic test_cost_extremes();
        set_costs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(30);
        drain();
        set_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(30);
        drain();
    endtask

    task automatic test_output_hold();
        int k;
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        for (k = 0; k < 12; k++) send_item(pick_command(), pick_address(), $urandom);
        gaps_on = 1'b1;
        drain();
    endtask

    task automatic test_sender_pause();
        set_costs(16'd7, 16'd3, 16'd2, 16'd5);
        run_random(10);
        drain();
        run_random(10);
        drain();
    endtask

    task automatic test_no_idle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random(60);
        drain();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_mix();
        int k;
        for (k = 0; k < 5; k++) begin
            set_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom),
                      COST_W'($urandom));
            run_random(50);
            drain();
        end
    endtask

    // receiver: random stall per result, or one long hold when asked
    initial begin : result_sink
        int n;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = LONG_HOLD;
            end else begin
                n = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    task automatic check_field(input string label, input logic [DATA_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_access_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none expected, expected none actual time %h",
                         $time, o_elapsed_time);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("read_data",    want.read_data,    o_read_data);
                check_field("hit",          want.hit,          o_hit);
                check_field("wrote_back",   want.wrote_back,   o_wrote_back);
                check_field("elapsed_time", want.elapsed_time, o_elapsed_time);
            end
        end
    end

    initial begin
        apply_reset();
        test_directed();
        test_cost_extremes();
        test_output_hold();
        test_sender_pause();
        test_no_idle();
        test_random_mix();
        drain();
        repeat (END_WAIT) @(negedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
